// ----- hdl/gd3_pkg.sv -----
package gd3_pkg;

  localparam int VOXEL_BITS = 16;
  localparam int PLANE_BITS = 12;
  localparam int MAX_PLANES = 4096;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 13;
  localparam int TAPS_PER_PLANE = 9;

  typedef logic signed [VOXEL_BITS-1:0] voxel_t;

  localparam voxel_t VOXEL_MIN = {1'b1, {(VOXEL_BITS-1){1'b0}}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_NEIGHBOUR_MODE
  } cfg_reg_t;

  localparam logic [1:0] NBR_FACE = 2'd0;
  localparam logic [1:0] NBR_EDGE = 2'd1;
  localparam logic [1:0] NBR_FULL = 2'd2;

  typedef struct packed {
    voxel_t voxel_value;
    logic   is_padding;
  } in_item_t;

  typedef struct packed {
    voxel_t dilated_value;
    logic   last_of_volume;
  } out_item_t;

  // taps of one plane: index row*3 + col, lag row*X + col
  typedef voxel_t [TAPS_PER_PLANE-1:0] plane_taps_t;
  typedef plane_taps_t [2:0] window_t;

  typedef struct packed {
    logic       border;
    logic       last;
    logic [1:0] mode;
  } emit_info_t;

endpackage

// ----- hdl/grey_dilation_3d_stream_core.sv -----
// A result reaches the output register along these steps from the accept of the item that
// completes it: history read and window load at that edge, then row max, plane max, final max.
// Throughput: one item per cycle unless the output stalls, set by the plane cells' tap shift
// and one-read one-write history and line memories; input waits for settle after cfg writes.
// Reset: synchronous, clears counters, pointers and valid bits; memories keep their contents
// and are not cleared.
module grey_dilation_3d_stream_core #(
  parameter int MAX_ROW_LEN = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  voxel_valid,
  output logic                                  voxel_ready,
  input  gd3_pkg::in_item_t                     voxel_item,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output gd3_pkg::out_item_t                    result_item,
  input  logic                                  cfg_we,
  input  logic [gd3_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [gd3_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int CW        = $clog2(MAX_ROW_LEN);
  localparam int RW        = $clog2(MAX_ROWS);
  localparam int ZW        = gd3_pkg::PLANE_BITS;
  localparam int SXW       = CW + 1;
  localparam int SYW       = RW + 1;
  localparam int SZW       = ZW + 1;
  localparam int PLANE_MAX = MAX_ROW_LEN * MAX_ROWS;
  localparam int PLW       = $clog2(PLANE_MAX) + 1;
  localparam int DMAX      = PLANE_MAX + MAX_ROW_LEN + 1;
  localparam int DW        = $clog2(DMAX + 2);
  localparam int HA        = $clog2(DMAX + 1);
  localparam int HDEPTH    = 2 ** HA;
  localparam logic [1:0] SETTLE = 2'd2;

  // configuration registers
  logic [8:0]  size_x;
  logic [8:0]  size_y;
  logic [12:0] size_z;
  logic [1:0]  neighbour_mode;
  logic [1:0]  settle;

  // derived sizes
  logic [SXW-1:0]     sx;
  logic [SYW-1:0]     sy;
  logic [SZW-1:0]     sz;
  logic [1:0]         mode_c;
  logic [SXW+SYW-1:0] xy_prod;
  logic [DW-1:0]      delay_len;
  logic [PLW-1:0]     plane_len;
  logic [SXW-1:0]     row_len;

  // stream state
  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;
  logic [ZW-1:0] in_plane, out_plane;
  logic [DW-1:0] pending, pend_inc, pending_next;
  logic [HA-1:0] wr_ptr, wr_next, center_addr;

  logic accept, vox, pad, emit, in_origin;
  logic in_col_wrap, in_row_wrap, in_plane_wrap;
  logic out_col_wrap, out_row_wrap, out_plane_wrap;
  logic border, last;

  gd3_pkg::voxel_t    hist [HDEPTH];
  gd3_pkg::voxel_t    center_q;
  gd3_pkg::emit_info_t a_info;
  logic               a_valid, a_ready;

  gd3_pkg::voxel_t    plane_in [3];
  gd3_pkg::window_t   win;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x         <= 9'd256;
      size_y         <= 9'd256;
      size_z         <= 13'd256;
      neighbour_mode <= gd3_pkg::NBR_FULL;
      settle         <= SETTLE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gd3_pkg::REG_SIZE_X:         size_x         <= cfg_data[8:0];
          gd3_pkg::REG_SIZE_Y:         size_y         <= cfg_data[8:0];
          gd3_pkg::REG_SIZE_Z:         size_z         <= cfg_data;
          gd3_pkg::REG_NEIGHBOUR_MODE: neighbour_mode <= cfg_data[1:0];
        endcase
        settle <= SETTLE;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  // two register levels: clamp, then product and lengths
  always_ff @(posedge clk) begin
    sx <= (size_x == '0) ? SXW'(1) :
          (int'(size_x) > MAX_ROW_LEN) ? SXW'(MAX_ROW_LEN) : SXW'(size_x);
    sy <= (size_y == '0) ? SYW'(1) :
          (int'(size_y) > MAX_ROWS) ? SYW'(MAX_ROWS) : SYW'(size_y);
    sz <= (size_z == '0) ? SZW'(1) :
          (int'(size_z) > gd3_pkg::MAX_PLANES) ? SZW'(gd3_pkg::MAX_PLANES) : SZW'(size_z);
    mode_c    <= (neighbour_mode > gd3_pkg::NBR_FULL) ?
                 gd3_pkg::NBR_FULL : neighbour_mode;
    delay_len <= DW'(xy_prod + (SXW+SYW)'(sx) + (SXW+SYW)'(1));
    plane_len <= (xy_prod > (SXW+SYW)'(1)) ? PLW'(xy_prod - (SXW+SYW)'(1)) : PLW'(1);
    row_len   <= (sx > SXW'(1)) ? (sx - SXW'(1)) : SXW'(1);
  end

  assign xy_prod = (SXW+SYW)'(sx) * (SXW+SYW)'(sy);

  assign voxel_ready = (!a_valid || a_ready) && (settle == 2'd0);
  assign accept      = voxel_valid && voxel_ready;
  assign pad         = voxel_item.is_padding;
  assign vox         = accept && !pad;

  assign in_col_wrap   = (SXW'(in_col) + SXW'(1)) >= sx;
  assign in_row_wrap   = (SYW'(in_row) + SYW'(1)) >= sy;
  assign in_plane_wrap = (SZW'(in_plane) + SZW'(1)) >= sz;
  assign in_origin     = (in_col == '0) && (in_row == '0) && (in_plane == '0);

  assign out_col_wrap   = (SXW'(out_col) + SXW'(1)) >= sx;
  assign out_row_wrap   = (SYW'(out_row) + SYW'(1)) >= sy;
  assign out_plane_wrap = (SZW'(out_plane) + SZW'(1)) >= sz;

  assign pend_inc     = pending + DW'(vox);
  // drain only between volumes, with the input position back at the origin
  assign emit         = accept && ((pend_inc > delay_len) ||
                                   (pad && (pending != '0) && in_origin));
  assign pending_next = pend_inc - DW'(emit);
  assign wr_next      = wr_ptr + HA'(vox);
  assign center_addr  = wr_next - pend_inc[HA-1:0];

  assign border = (out_col == '0) || out_col_wrap || (out_row == '0) || out_row_wrap ||
                  (out_plane == '0) || out_plane_wrap;
  assign last   = ((SXW'(out_col) + SXW'(1)) == sx) && ((SYW'(out_row) + SYW'(1)) == sy) &&
                  ((SZW'(out_plane) + SZW'(1)) == sz);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      wr_ptr    <= '0;
      in_col    <= '0;
      in_row    <= '0;
      in_plane  <= '0;
      out_col   <= '0;
      out_row   <= '0;
      out_plane <= '0;
      a_valid   <= 1'b0;
    end else begin
      pending <= pending_next;
      wr_ptr  <= wr_next;
      if (vox) begin
        if (in_col_wrap) begin
          in_col <= '0;
          if (in_row_wrap) begin
            in_row   <= '0;
            in_plane <= in_plane_wrap ? '0 : in_plane + ZW'(1);
          end else begin
            in_row <= in_row + RW'(1);
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (emit) begin
        if (out_col_wrap) begin
          out_col <= '0;
          if (out_row_wrap) begin
            out_row   <= '0;
            out_plane <= out_plane_wrap ? '0 : out_plane + ZW'(1);
          end else begin
            out_row <= out_row + RW'(1);
          end
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
      if (emit) begin
        a_valid <= 1'b1;
      end else if (a_ready) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vox) hist[wr_ptr] <= voxel_item.voxel_value;
    if (emit) begin
      center_q    <= hist[center_addr];
      a_info.border <= border;
      a_info.last   <= last;
      a_info.mode   <= mode_c;
    end
  end

  assign plane_in[0] = voxel_item.voxel_value;

  for (genvar k = 0; k < 2; k++) begin : g_plane
    gd3_delay #(.DEPTH(PLANE_MAX)) u_plane (
      .clk   (clk),
      .rst   (rst),
      .clear (cfg_we),
      .shift (vox),
      .len   (plane_len),
      .din   (plane_in[k]),
      .dout  (plane_in[k+1])
    );
  end

  for (genvar k = 0; k < 3; k++) begin : g_cell
    gd3_cell #(.MAX_ROW_LEN(MAX_ROW_LEN)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (cfg_we),
      .shift   (vox),
      .row_len (row_len),
      .din     (plane_in[k]),
      .taps    (win[k])
    );
  end

  gd3_reduce u_reduce (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (a_valid),
    .in_ready     (a_ready),
    .window       (win),
    .center       (center_q),
    .info         (a_info),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

// ----- hdl/gd3_delay.sv -----
module gd3_delay #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     shift,
  input  logic [$clog2(DEPTH):0]   len,
  input  gd3_pkg::voxel_t          din,
  output gd3_pkg::voxel_t          dout
);

  localparam int AW = $clog2(DEPTH);

  gd3_pkg::voxel_t mem [DEPTH];
  logic [AW-1:0]   ptr;

  always_ff @(posedge clk) begin
    if (shift) begin
      dout     <= mem[ptr];
      mem[ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ptr <= '0;
    end else if (shift) begin
      if (({1'b0, ptr} + (AW+1)'(1)) >= len) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + AW'(1);
      end
    end
  end

endmodule

// ----- hdl/gd3_cell.sv -----
module gd3_cell #(
  parameter int MAX_ROW_LEN = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          shift,
  input  logic [$clog2(MAX_ROW_LEN):0]  row_len,
  input  gd3_pkg::voxel_t               din,
  output gd3_pkg::plane_taps_t          taps
);

  gd3_pkg::voxel_t row1;
  gd3_pkg::voxel_t row2;

  gd3_delay #(.DEPTH(MAX_ROW_LEN)) u_row1 (
    .clk   (clk),
    .rst   (rst),
    .clear (clear),
    .shift (shift),
    .len   (row_len),
    .din   (din),
    .dout  (row1)
  );

  gd3_delay #(.DEPTH(MAX_ROW_LEN)) u_row2 (
    .clk   (clk),
    .rst   (rst),
    .clear (clear),
    .shift (shift),
    .len   (row_len),
    .din   (row1),
    .dout  (row2)
  );

  always_ff @(posedge clk) begin
    if (shift) begin
      taps[0] <= din;
      taps[1] <= taps[0];
      taps[2] <= taps[1];
      taps[3] <= row1;
      taps[4] <= taps[3];
      taps[5] <= taps[4];
      taps[6] <= row2;
      taps[7] <= taps[6];
      taps[8] <= taps[7];
    end
  end

endmodule

// ----- hdl/gd3_reduce.sv -----
module gd3_reduce (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gd3_pkg::window_t     window,
  input  gd3_pkg::voxel_t      center,
  input  gd3_pkg::emit_info_t  info,
  output logic                 result_valid,
  input  logic                 result_ready,
  output gd3_pkg::out_item_t   result_item
);

  function automatic gd3_pkg::voxel_t vmax(gd3_pkg::voxel_t p, gd3_pkg::voxel_t q);
    return ($signed(p) > $signed(q)) ? p : q;
  endfunction

  function automatic logic tap_on(logic [1:0] mode, int a, int b, int c);
    int hops;
    hops = int'(a != 1) + int'(b != 1) + int'(c != 1);
    return (hops != 0) && (hops <= int'(mode) + 1);
  endfunction

  logic b_valid, c_valid;
  logic b_free, c_free, d_free;

  gd3_pkg::voxel_t row_max [9];
  gd3_pkg::voxel_t b_rows [9];
  gd3_pkg::voxel_t b_center;
  logic            b_border, b_last;

  gd3_pkg::voxel_t plane_max [3];
  gd3_pkg::voxel_t c_planes [3];
  gd3_pkg::voxel_t c_center;
  logic            c_border, c_last;

  gd3_pkg::voxel_t final_value;

  assign d_free   = !result_valid || result_ready;
  assign c_free   = !c_valid || d_free;
  assign b_free   = !b_valid || c_free;
  assign in_ready = b_free;

  // masked neighbors fall back to the most negative value
  always_comb begin : row_reduce
    gd3_pkg::voxel_t m;
    gd3_pkg::voxel_t v;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        m = gd3_pkg::VOXEL_MIN;
        for (int c = 0; c < 3; c++) begin
          v = tap_on(info.mode, a, b, c) ? window[a][b*3+c] : gd3_pkg::VOXEL_MIN;
          m = vmax(m, v);
        end
        row_max[a*3+b] = m;
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      plane_max[a] = vmax(vmax(b_rows[a*3], b_rows[a*3+1]), b_rows[a*3+2]);
    end
  end

  assign final_value = c_border ? c_center :
                       vmax(vmax(c_center, c_planes[0]), vmax(c_planes[1], c_planes[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (b_free) b_valid <= in_valid;
      if (c_free) c_valid <= b_valid;
      if (d_free) result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && in_valid) begin
      b_rows   <= row_max;
      b_center <= center;
      b_border <= info.border;
      b_last   <= info.last;
    end
    if (c_free && b_valid) begin
      c_planes <= plane_max;
      c_center <= b_center;
      c_border <= b_border;
      c_last   <= b_last;
    end
    if (d_free && c_valid) begin
      result_item.dilated_value  <= final_value;
      result_item.last_of_volume <= c_last;
    end
  end

endmodule
